>>> rtl/job_timeout_tracker_macros.svh
// ----------------------------------------------------------------------------
// job timeout tracker assertion macros
// shared property wrappers for clocked checks under reset
// ----------------------------------------------------------------------------
`ifndef JOB_TIMEOUT_TRACKER_MACROS_SVH
`define JOB_TIMEOUT_TRACKER_MACROS_SVH

// same-cycle implication
`define JTT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/jtt_pkg.sv
// ----------------------------------------------------------------------------
// jtt_pkg
// types and constants of the job timeout tracker
// ----------------------------------------------------------------------------
package jtt_pkg;

  localparam int KIND_W    = 3;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int STAMP_W   = 32;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [KIND_W-1:0] {
    KIND_ISSUE     = 3'd0,
    KIND_ISSUE_CO  = 3'd1,
    KIND_CHECKOUT  = 3'd2,
    KIND_COMPLETE  = 3'd3,
    KIND_TICK      = 3'd4,
    KIND_QUERY     = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_MOD,
    ST_SCAN,
    ST_DRAIN,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic               issued;
    logic               checked_out;
    logic               completed;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

>>> rtl/job_timeout_tracker.sv
// ----------------------------------------------------------------------------
// job_timeout_tracker
// table of outstanding jobs with checkout stamps, expiry and age scan
// ----------------------------------------------------------------------------
// Usage:
// - s_axis carries one command per transaction: tuser holds the kind (issue,
//   issue with checkout, checkout, complete, tick, query), tdata the entry.
// - m_axis returns one result per command: the entry flags, completed count,
//   oldest active entry, first expired entry and the error flag.
// - cfg_wr_en_i/cfg_wr_data_i load the timeout; write only while idle.
// - Each command runs one read-modify-write of the entry memory, then a
//   scan that reads one entry per cycle over the single read port, then a
//   pipeline drain and the output load.
// - The next command is accepted once the previous result sits in the
//   output register; if the receiver stalls, the finished result waits in
//   the scan unit until the output register frees up.
// - Reset clears the tick counter, timeout, control state and the per-entry
//   valid bits; the stamp memory itself is not cleared, no clearing pass.
// ----------------------------------------------------------------------------
`include "job_timeout_tracker_macros.svh"

module job_timeout_tracker #(
  parameter int NUM_ENTRIES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_wr_en_i,
  input  logic [31:0]                    cfg_wr_data_i,
  // command stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [jtt_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // [5:0] entry_index
  input  logic [jtt_pkg::KIND_W-1:0]     s_axis_tuser_i,  // [2:0] kind
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [0] entry_checked_out, [1] entry_completed, [8:2] completed_count,
  // [9] oldest_found, [15:10] oldest_index, [16] expired_found,
  // [22:17] expired_index, [23] error_code
  output logic [jtt_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int CW = $clog2(NUM_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_ENTRIES - 1);
  localparam int IW = jtt_pkg::IDX_W;
  localparam int SW = jtt_pkg::STAMP_W;

  // control
  jtt_pkg::state_e state_q, state_d;
  logic [SW-1:0]   timeout_q;
  logic [SW-1:0]   now_q;
  logic            vld_q [NUM_ENTRIES];

  // command
  jtt_pkg::kind_e  kind_q;
  logic [AW-1:0]   addr_q;
  logic            idx_ok_q;

  // entry memory
  jtt_pkg::entry_t mem_q [NUM_ENTRIES];
  jtt_pkg::entry_t mem_rd_q;
  logic [AW-1:0]   rd_addr;
  logic            rd_ev_q;
  logic            wr_en;
  jtt_pkg::entry_t wr_ent;

  // read-modify-write results
  logic            eco_q, ecp_q, err_q;
  jtt_pkg::entry_t cur_ent;
  logic            do_write;
  logic            err_d;

  // scan pipeline
  logic [AW-1:0]   scan_q;
  logic            p1_vld_q;
  logic [AW-1:0]   p1_idx_q;
  logic            p2_vld_q, p2_comp_q, p2_act_q, p2_iss_q;
  logic [AW-1:0]   p2_idx_q;
  logic [SW-1:0]   p2_age_q;
  jtt_pkg::entry_t p1_ent;

  // accumulators
  logic [CW-1:0]   cnt_q;
  logic            old_found_q, exp_found_q;
  logic [AW-1:0]   old_idx_q, exp_idx_q;
  logic [SW-1:0]   old_age_q;

  // output register
  logic                          m_valid_q;
  logic [jtt_pkg::OUT_DATA_W-1:0] m_data_q;
  logic                          load_out;

  logic                     s_fire;
  logic [AW+IW-1:0]         s_idx_ext;
  logic                     s_idx_ok;
  logic [CW+jtt_pkg::CNT_W-1:0] cnt_ext;
  logic [AW+IW-1:0]         old_idx_ext, exp_idx_ext;

  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign s_idx_ext = {{AW{1'b0}}, s_axis_tdata_i[IW-1:0]};
  assign s_idx_ok  = {{(32-IW){1'b0}}, s_axis_tdata_i[IW-1:0]} < 32'(NUM_ENTRIES);

  // --------------------------------------------------------------------------
  // state machine
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jtt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    rd_addr         = scan_q;
    load_out        = 1'b0;
    wr_en           = 1'b0;
    unique case (state_q)
      jtt_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          state_d = jtt_pkg::ST_RD;
        end
      end
      jtt_pkg::ST_RD: begin
        rd_addr = addr_q;
        state_d = jtt_pkg::ST_MOD;
      end
      jtt_pkg::ST_MOD: begin
        // write lands before the scan reads start, so no overlap on one entry
        wr_en   = do_write;
        state_d = jtt_pkg::ST_SCAN;
      end
      jtt_pkg::ST_SCAN: begin
        if (scan_q == LAST_ADDR) begin
          state_d = jtt_pkg::ST_DRAIN;
        end
      end
      jtt_pkg::ST_DRAIN: begin
        if (!p1_vld_q && !p2_vld_q) begin
          state_d = jtt_pkg::ST_PUSH;
        end
      end
      jtt_pkg::ST_PUSH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = jtt_pkg::ST_IDLE;
        end
      end
      default: state_d = jtt_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // configuration, tick counter and command capture
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= '0;
      now_q     <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        timeout_q <= cfg_wr_data_i;
      end
      if (s_fire && (jtt_pkg::kind_e'(s_axis_tuser_i) == jtt_pkg::KIND_TICK)) begin
        now_q <= now_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      kind_q   <= jtt_pkg::kind_e'(s_axis_tuser_i);
      addr_q   <= s_idx_ext[AW-1:0];
      idx_ok_q <= s_idx_ok;
    end
  end

  // --------------------------------------------------------------------------
  // entry memory: one write port, one registered read port
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    mem_rd_q <= mem_q[rd_addr];
    if (wr_en) begin
      mem_q[addr_q] <= wr_ent;
    end
  end

  // valid bits stand in for the cleared flags after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        vld_q[i] <= 1'b0;
      end
      rd_ev_q <= 1'b0;
    end else begin
      rd_ev_q <= vld_q[rd_addr];
      if (wr_en) begin
        vld_q[addr_q] <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // modify step
  // --------------------------------------------------------------------------
  always_comb begin
    cur_ent             = mem_rd_q;
    cur_ent.issued      = mem_rd_q.issued && rd_ev_q;
    cur_ent.checked_out = mem_rd_q.checked_out && rd_ev_q;
    cur_ent.completed   = mem_rd_q.completed && rd_ev_q;
    wr_ent              = cur_ent;
    do_write            = 1'b0;
    err_d               = 1'b0;
    if (idx_ok_q) begin
      unique case (kind_q)
        jtt_pkg::KIND_ISSUE, jtt_pkg::KIND_ISSUE_CO: begin
          do_write           = 1'b1;
          wr_ent.issued      = 1'b1;
          wr_ent.checked_out = 1'b0;
          wr_ent.completed   = 1'b0;
          if (kind_q == jtt_pkg::KIND_ISSUE_CO) begin
            wr_ent.checked_out = 1'b1;
            wr_ent.stamp       = now_q;
          end
        end
        jtt_pkg::KIND_CHECKOUT: begin
          if (cur_ent.issued) begin
            do_write           = 1'b1;
            wr_ent.checked_out = 1'b1;
            wr_ent.stamp       = now_q;
          end else begin
            err_d = 1'b1;
          end
        end
        jtt_pkg::KIND_COMPLETE: begin
          do_write = 1'b1;
          if (!cur_ent.checked_out) begin
            wr_ent.checked_out = 1'b1;
            wr_ent.stamp       = now_q;
          end
          wr_ent.completed = 1'b1;
        end
        default: begin
          do_write = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == jtt_pkg::ST_MOD) begin
      eco_q <= idx_ok_q && wr_ent.checked_out;
      ecp_q <= idx_ok_q && wr_ent.completed;
      err_q <= err_d;
    end
  end

  // --------------------------------------------------------------------------
  // scan: address, age, accumulate
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q   <= '0;
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= (state_q == jtt_pkg::ST_SCAN);
      p2_vld_q <= p1_vld_q;
      if (state_q == jtt_pkg::ST_SCAN) begin
        scan_q <= scan_q + AW'(1);
      end else begin
        scan_q <= '0;
      end
    end
  end

  always_comb begin
    p1_ent             = mem_rd_q;
    p1_ent.issued      = mem_rd_q.issued && rd_ev_q;
    p1_ent.checked_out = mem_rd_q.checked_out && rd_ev_q;
    p1_ent.completed   = mem_rd_q.completed && rd_ev_q;
  end

  always_ff @(posedge clk_i) begin
    p1_idx_q  <= scan_q;
    p2_idx_q  <= p1_idx_q;
    p2_comp_q <= p1_ent.completed;
    p2_act_q  <= p1_ent.checked_out && !p1_ent.completed;
    p2_iss_q  <= p1_ent.issued;
    p2_age_q  <= now_q - mem_rd_q.stamp;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == jtt_pkg::ST_MOD) begin
      cnt_q       <= '0;
      old_found_q <= 1'b0;
      exp_found_q <= 1'b0;
      old_idx_q   <= '0;
      exp_idx_q   <= '0;
      old_age_q   <= '0;
    end else if (p2_vld_q) begin
      cnt_q <= cnt_q + CW'(p2_comp_q);
      if (p2_act_q) begin
        if (!old_found_q || (p2_age_q > old_age_q)) begin
          old_found_q <= 1'b1;
          old_age_q   <= p2_age_q;
          old_idx_q   <= p2_idx_q;
        end
        if (!exp_found_q && p2_iss_q && (p2_age_q > timeout_q)) begin
          exp_found_q <= 1'b1;
          exp_idx_q   <= p2_idx_q;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  assign cnt_ext     = {{jtt_pkg::CNT_W{1'b0}}, cnt_q};
  assign old_idx_ext = {{IW{1'b0}}, old_idx_q};
  assign exp_idx_ext = {{IW{1'b0}}, exp_idx_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {err_q, exp_idx_ext[IW-1:0], exp_found_q, old_idx_ext[IW-1:0],
                   old_found_q, cnt_ext[jtt_pkg::CNT_W-1:0], ecp_q, eco_q};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `JTT_ASSERT_NEXT(a_accept_starts_read, s_fire, state_q == jtt_pkg::ST_RD,
    "accepted transaction did not start the entry read")
  `JTT_ASSERT_NEXT(a_scan_ends, (state_q == jtt_pkg::ST_SCAN) && (scan_q == LAST_ADDR),
    state_q == jtt_pkg::ST_DRAIN, "scan ran past the last entry")
  `JTT_ASSERT_SAME(a_expired_is_active, (state_q == jtt_pkg::ST_PUSH) && exp_found_q,
    old_found_q, "expired entry found without any active entry")
  `JTT_ASSERT_SAME(a_count_bound, state_q == jtt_pkg::ST_PUSH,
    cnt_q <= CW'(NUM_ENTRIES), "completed count exceeds table size")

endmodule
